@@ rtl/core/npic_pkg.sv @@
// shared types and constants of the nested priority interrupt controller
package npic_pkg;

  localparam int unsigned NumSrc   = 16;
  localparam int unsigned PrioBits = 2;
  localparam int unsigned SrcW     = $clog2(NumSrc);
  localparam int unsigned CntW     = $clog2(NumSrc + 1);

  typedef logic [SrcW-1:0]     src_t;
  typedef logic [CntW-1:0]     cnt_t;
  typedef logic [PrioBits-1:0] prio_t;

  // event codes
  typedef enum logic [2:0] {
    FUNC_RAISE  = 3'd0,
    FUNC_CLEAR  = 3'd1,
    FUNC_WRITE  = 3'd2,
    FUNC_ENABLE = 3'd3,
    FUNC_GLOBAL = 3'd4,
    FUNC_TICK   = 3'd5,
    FUNC_RETURN = 3'd6,
    FUNC_NONE   = 3'd7
  } func_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_PRIO  = 2'd0,
    REG_ACLR  = 2'd1,
    REG_REMEM = 2'd2,
    REG_FPOS  = 2'd3
  } reg_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_QSCAN,
    ST_QSHIFT,
    ST_INSERT,
    ST_USCAN,
    ST_USHIFT,
    ST_HEAD,
    ST_POP,
    ST_REQ,
    ST_OUT
  } state_e;

  // request from the sequencer to the list memory
  typedef struct packed {
    logic rd_en;
    logic [SrcW-1:0] rd_addr;
    logic wr_en;
    logic wr_sel;   // 0 pending list, 1 preempted stack
    logic [SrcW-1:0] wr_addr;
    src_t wr_data;
    logic rd_sel;
  } mem_req_t;

endpackage

@@ rtl/core/nested_priority_interrupt_controller_unit.sv @@
// top level of the nested priority interrupt controller
// One event beat is taken at a time and its result beat is held in an output
// register; the next event is accepted in the cycle after that result is taken.
// Queueing a source walks the pending list in the list memory one entry per
// cycle to look for the source and its insertion point, then moves the entries
// behind that point up one per cycle. Clearing a queued flag walks the list
// and closes the gap. A return that clears its flag and then re-queues a
// preempted source does both.
// Configuration is to be written by the user only while no event is in
// flight; the block itself does not enforce it.
module nested_priority_interrupt_controller_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  func_i,
  input  logic [3:0]  source_i,
  input  logic [7:0]  value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        taken_o,
  output logic [3:0]  taken_source_o,
  output logic        active_valid_o,
  output logic [3:0]  active_source_o,
  output logic [15:0] flags_o,
  output logic        raise_notify_o,
  output logic        exit_notify_o,
  output logic        return_error_o
);

  // configuration
  logic [31:0] prio_map_q;
  logic [15:0] aclr_q, remem_q;
  logic [47:0] fpos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prio_map_q <= '0;
      aclr_q     <= '0;
      remem_q    <= '0;
      fpos_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (npic_pkg::reg_e'(cfg_index_i))
        npic_pkg::REG_PRIO:  prio_map_q <= cfg_data_i[31:0];
        npic_pkg::REG_ACLR:  aclr_q     <= cfg_data_i[15:0];
        npic_pkg::REG_REMEM: remem_q    <= cfg_data_i[15:0];
        npic_pkg::REG_FPOS:  fpos_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  function automatic npic_pkg::prio_t prio_of(logic [31:0] m, npic_pkg::src_t s);
    return m[s*npic_pkg::PrioBits +: npic_pkg::PrioBits];
  endfunction

  // state
  npic_pkg::state_e state_q, state_d;
  logic [15:0] flags_q, flags_d, en_q, en_d;
  logic [7:0]  gcnt_q, gcnt_d;
  npic_pkg::cnt_t pcnt_q, pcnt_d, scnt_q, scnt_d;
  logic act_q, act_d;
  npic_pkg::src_t aidx_q, aidx_d;
  npic_pkg::func_e func_q, func_d;
  npic_pkg::src_t src_q, src_d;
  logic [7:0] val_q, val_d;
  // walk pointer, insert point, found flag, source under queue/unqueue
  npic_pkg::cnt_t ptr_q, ptr_d, at_q, at_d;
  logic atset_q, atset_d;
  npic_pkg::src_t qs_q, qs_d;
  logic req_q, req_d;          // requeue pending after removal
  logic ov_q, ov_d, tk_q, tk_d, rn_q, rn_d, xn_q, xn_d, re_q, re_d;
  npic_pkg::src_t ts_q, ts_d;

  npic_pkg::mem_req_t req;
  npic_pkg::src_t rd_data;

  npic_list_mem u_mem (.clk_i(clk_i), .req_i(req), .rd_data_o(rd_data));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= npic_pkg::ST_IDLE;
      flags_q <= '0; en_q <= '0; gcnt_q <= '0;
      pcnt_q <= '0; scnt_q <= '0; act_q <= 1'b0; aidx_q <= '0;
      ov_q <= 1'b0; req_q <= 1'b0; atset_q <= 1'b0;
    end else begin
      state_q <= state_d;
      flags_q <= flags_d; en_q <= en_d; gcnt_q <= gcnt_d;
      pcnt_q <= pcnt_d; scnt_q <= scnt_d; act_q <= act_d; aidx_q <= aidx_d;
      ov_q <= ov_d; req_q <= req_d; atset_q <= atset_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d; src_q <= src_d; val_q <= val_d;
    ptr_q <= ptr_d; at_q <= at_d; qs_q <= qs_d;
    tk_q <= tk_d; rn_q <= rn_d; xn_q <= xn_d; re_q <= re_d; ts_q <= ts_d;
  end

  assign in_ready_o = (state_q == npic_pkg::ST_IDLE) && !ov_q;
  assign out_valid_o = ov_q;

  // sequencer
  always_comb begin
    logic [15:0] b;
    b = 16'(1) << src_q;
    state_d = state_q;
    flags_d = flags_q; en_d = en_q; gcnt_d = gcnt_q;
    pcnt_d = pcnt_q; scnt_d = scnt_q; act_d = act_q; aidx_d = aidx_q;
    func_d = func_q; src_d = src_q; val_d = val_q;
    ptr_d = ptr_q; at_d = at_q; atset_d = atset_q; qs_d = qs_q;
    req_d = req_q;
    ov_d = ov_q; tk_d = tk_q; rn_d = rn_q; xn_d = xn_q; re_d = re_q; ts_d = ts_q;
    req = '0;
    if (ov_q && out_ready_i) ov_d = 1'b0;

    unique case (state_q)
      npic_pkg::ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          func_d = npic_pkg::func_e'(func_i);
          src_d = source_i; val_d = value_i;
          tk_d = 1'b0; ts_d = '0; rn_d = 1'b0; xn_d = 1'b0; re_d = 1'b0;
          req_d = 1'b0;
          state_d = npic_pkg::ST_DECODE;
        end
      end
      npic_pkg::ST_DECODE: begin
        state_d = npic_pkg::ST_OUT;
        ptr_d = '0; atset_d = 1'b0; at_d = pcnt_q;
        unique case (func_q) inside
          npic_pkg::FUNC_RAISE: begin
            if (!(flags_q[src_q])) begin
              flags_d = flags_q | b;
              if (en_q[src_q]) begin
                rn_d = 1'b1; qs_d = src_q;
                state_d = npic_pkg::ST_QSCAN;
              end
            end
          end
          npic_pkg::FUNC_CLEAR, npic_pkg::FUNC_WRITE: begin
            if (flags_q[src_q] && (func_q == npic_pkg::FUNC_CLEAR ||
                val_q[fpos_q[src_q*3 +: 3]])) begin
              flags_d = flags_q & ~b; qs_d = src_q;
              state_d = npic_pkg::ST_USCAN;
            end
          end
          npic_pkg::FUNC_ENABLE: begin
            if (val_q[0] != en_q[src_q]) begin
              en_d = val_q[0] ? (en_q | b) : (en_q & ~b);
              if (val_q[0] && flags_q[src_q] && remem_q[src_q]) begin
                qs_d = src_q; state_d = npic_pkg::ST_QSCAN;
              end
            end
          end
          npic_pkg::FUNC_GLOBAL: gcnt_d = val_q;
          npic_pkg::FUNC_TICK: begin
            if (gcnt_q > 8'd1) gcnt_d = gcnt_q - 8'd1;
            else if (gcnt_q == 8'd1 && pcnt_q != '0) begin
              req.rd_en = 1'b1; req.rd_addr = '0;
              state_d = npic_pkg::ST_HEAD;
            end
          end
          npic_pkg::FUNC_RETURN: begin
            if (!act_q) re_d = 1'b1;
            else begin
              xn_d = 1'b1; act_d = 1'b0;
              if (scnt_q != '0) begin
                scnt_d = scnt_q - 1'b1;
                req_d = 1'b1;
              end
              if (aclr_q[aidx_q] && flags_q[aidx_q]) begin
                flags_d = flags_q & ~(16'(1) << aidx_q);
                qs_d = aidx_q;
                state_d = npic_pkg::ST_USCAN;
              end else if (scnt_q != '0) begin
                // stack top read for the re-queue
                req.rd_en = 1'b1; req.rd_sel = 1'b1;
                req.rd_addr = npic_pkg::SrcW'(scnt_q - 1'b1);
                state_d = npic_pkg::ST_POP;
              end
            end
          end
          default: ;
        endcase
        if (state_d == npic_pkg::ST_QSCAN || state_d == npic_pkg::ST_USCAN) begin
          if (pcnt_q != '0) begin
            req.rd_en = 1'b1; req.rd_addr = '0;
          end
        end
      end
      npic_pkg::ST_POP: begin
        // stack top read issued in decode
        qs_d = rd_data; req_d = 1'b0; ptr_d = '0; atset_d = 1'b0; at_d = pcnt_q;
        state_d = npic_pkg::ST_QSCAN;
        if (pcnt_q != '0) begin
          req.rd_en = 1'b1; req.rd_addr = '0;
        end
      end
      npic_pkg::ST_REQ: begin
        qs_d = rd_data; req_d = 1'b0; ptr_d = '0; atset_d = 1'b0; at_d = pcnt_q;
        state_d = npic_pkg::ST_QSCAN;
        if (pcnt_q != '0) begin
          req.rd_en = 1'b1; req.rd_addr = '0;
        end
      end
      npic_pkg::ST_QSCAN: begin
        // rd_data holds entry ptr_q when ptr_q below count
        if (ptr_q == pcnt_q) begin
          if (pcnt_q == npic_pkg::CntW'(npic_pkg::NumSrc)) state_d = npic_pkg::ST_OUT;
          else begin
            ptr_d = pcnt_q;
            if (at_q == pcnt_q) begin
              req.wr_en = 1'b1; req.wr_addr = npic_pkg::SrcW'(pcnt_q);
              req.wr_data = qs_q;
              pcnt_d = pcnt_q + 1'b1; state_d = npic_pkg::ST_OUT;
            end else begin
              req.rd_en = 1'b1; req.rd_addr = npic_pkg::SrcW'(pcnt_q - 1'b1);
              state_d = npic_pkg::ST_QSHIFT;
            end
          end
        end else if (rd_data == qs_q) begin
          state_d = npic_pkg::ST_OUT;
        end else begin
          if (!atset_q && prio_of(prio_map_q, qs_q) > prio_of(prio_map_q, rd_data)) begin
            at_d = ptr_q; atset_d = 1'b1;
          end
          ptr_d = ptr_q + 1'b1;
          if (ptr_q + 1'b1 != pcnt_q) begin
            req.rd_en = 1'b1; req.rd_addr = npic_pkg::SrcW'(ptr_q + 1'b1);
          end
        end
      end
      npic_pkg::ST_QSHIFT: begin
        // move entry ptr-1 to ptr, reading ptr-2 next
        req.wr_en = 1'b1; req.wr_addr = npic_pkg::SrcW'(ptr_q); req.wr_data = rd_data;
        ptr_d = ptr_q - 1'b1;
        if (ptr_q - 1'b1 == at_q) state_d = npic_pkg::ST_INSERT;
        else begin
          req.rd_en = 1'b1; req.rd_addr = npic_pkg::SrcW'(ptr_q - 2'd2);
        end
      end
      npic_pkg::ST_INSERT: begin
        // new source into the opened slot
        req.wr_en = 1'b1; req.wr_addr = npic_pkg::SrcW'(at_q); req.wr_data = qs_q;
        pcnt_d = pcnt_q + 1'b1;
        state_d = npic_pkg::ST_OUT;
      end
      npic_pkg::ST_USCAN: begin
        if (ptr_q == pcnt_q) begin
          state_d = req_q ? npic_pkg::ST_REQ : npic_pkg::ST_OUT;
        end else if (rd_data == qs_q && !atset_q) begin
          atset_d = 1'b1; pcnt_d = pcnt_q - 1'b1;
          if (ptr_q + 1'b1 == pcnt_q) state_d = req_q ? npic_pkg::ST_REQ : npic_pkg::ST_OUT;
          else begin
            req.rd_en = 1'b1; req.rd_addr = npic_pkg::SrcW'(ptr_q + 1'b1);
            state_d = npic_pkg::ST_USHIFT;
          end
        end else begin
          ptr_d = ptr_q + 1'b1;
          if (ptr_q + 1'b1 != pcnt_q) begin
            req.rd_en = 1'b1; req.rd_addr = npic_pkg::SrcW'(ptr_q + 1'b1);
          end
        end
        if (state_d == npic_pkg::ST_REQ) begin
          req.rd_en = 1'b1; req.rd_sel = 1'b1; req.rd_addr = npic_pkg::SrcW'(scnt_q);
        end
      end
      npic_pkg::ST_USHIFT: begin
        // move entry ptr+1 down to ptr, reading ptr+2 next
        req.wr_en = 1'b1; req.wr_addr = npic_pkg::SrcW'(ptr_q); req.wr_data = rd_data;
        ptr_d = ptr_q + 1'b1;
        if (ptr_q + 1'b1 == pcnt_q) state_d = req_q ? npic_pkg::ST_REQ : npic_pkg::ST_OUT;
        else begin
          req.rd_en = 1'b1; req.rd_addr = npic_pkg::SrcW'(ptr_q + 2'd2);
        end
        if (state_d == npic_pkg::ST_REQ) begin
          req.rd_en = 1'b1; req.rd_sel = 1'b1; req.rd_addr = npic_pkg::SrcW'(scnt_q);
        end
      end
      npic_pkg::ST_HEAD: begin
        state_d = npic_pkg::ST_OUT;
        if (!act_q || prio_of(prio_map_q, rd_data) > prio_of(prio_map_q, aidx_q)) begin
          if (act_q && scnt_q != npic_pkg::CntW'(npic_pkg::NumSrc)) begin
            req.wr_en = 1'b1; req.wr_sel = 1'b1;
            req.wr_addr = npic_pkg::SrcW'(scnt_q); req.wr_data = aidx_q;
            scnt_d = scnt_q + 1'b1;
          end
          aidx_d = rd_data; act_d = 1'b1; tk_d = 1'b1; ts_d = rd_data;
        end
      end
      npic_pkg::ST_OUT: begin
        ov_d = 1'b1; state_d = npic_pkg::ST_IDLE;
      end
      default: state_d = npic_pkg::ST_IDLE;
    endcase
  end

  assign taken_o        = tk_q;
  assign taken_source_o = ts_q;
  assign active_valid_o = act_q;
  assign active_source_o = act_q ? aidx_q : '0;
  assign flags_o        = flags_q;
  assign raise_notify_o = rn_q;
  assign exit_notify_o  = xn_q;
  assign return_error_o = re_q;

endmodule

@@ rtl/core/npic_list_mem.sv @@
// list memories: pending list and preempted stack, with a registered read port
module npic_list_mem (
  input  logic               clk_i,
  input  npic_pkg::mem_req_t req_i,
  output npic_pkg::src_t     rd_data_o
);

  npic_pkg::src_t pend_mem [npic_pkg::NumSrc];
  npic_pkg::src_t stk_mem  [npic_pkg::NumSrc];

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      if (req_i.wr_sel) stk_mem[req_i.wr_addr] <= req_i.wr_data;
      else pend_mem[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_o <= req_i.rd_sel ? stk_mem[req_i.rd_addr] : pend_mem[req_i.rd_addr];
    end
  end

endmodule

@@ rtl/core/npic_checker.sv @@
// port-level checks of the interrupt controller, bound to the top level
module npic_port_checks (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        taken_o,
  input logic        active_valid_o,
  input logic [3:0]  active_source_o,
  input logic        exit_notify_o,
  input logic        return_error_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result beat dropped");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input taken while result waits");

  a_taken_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && taken_o |-> active_valid_o) else $error("dispatch without active");

  a_exit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (exit_notify_o || return_error_o) |-> !active_valid_o)
    else $error("active after return");

  a_src_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_valid_o |-> active_source_o == 4'd0) else $error("stale active source");

endmodule

bind nested_priority_interrupt_controller_unit npic_port_checks u_npic_checker (.*);

@@ dv/npic_checker.sv @@
// checker of the interrupt controller: predicts each result beat and compares it
module npic_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [2:0]  func_i,
  input  logic [3:0]  source_i,
  input  logic [7:0]  value_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        taken_i,
  input  logic [3:0]  taken_source_i,
  input  logic        active_valid_i,
  input  logic [3:0]  active_source_i,
  input  logic [15:0] flags_i,
  input  logic        raise_notify_i,
  input  logic        exit_notify_i,
  input  logic        return_error_i,
  output int          errors_o,
  output int          outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        taken;
    logic [3:0]  taken_src;
    logic        act_v;
    logic [3:0]  act_src;
    logic [15:0] flags;
    logic        rnot;
    logic        xnot;
    logic        rerr;
  } irq_res_t;

  // shadow configuration
  logic [31:0] prio_map;
  logic [15:0] aclr_mask;
  logic [15:0] remem_mask;
  logic [47:0] fpos_map;

  // shadow state
  logic [15:0]    raised;
  logic [15:0]    enables;
  logic [7:0]     gcount;
  npic_pkg::src_t pend[npic_pkg::NumSrc];
  int             pend_n;
  logic           act_v;
  npic_pkg::src_t act_src;
  npic_pkg::src_t stack[npic_pkg::NumSrc];
  int             stack_n;

  irq_res_t    res_q[$];

  assign outstanding_o = res_q.size();

  function automatic npic_pkg::prio_t prio_of(npic_pkg::src_t s);
    return npic_pkg::prio_t'(prio_map >> (s * npic_pkg::PrioBits));
  endfunction

  task automatic enqueue_src(npic_pkg::src_t s);
    int at;
    for (int i = 0; i < pend_n; i++) if (pend[i] == s) return;
    if (pend_n >= npic_pkg::NumSrc) return;
    at = pend_n;
    for (int i = 0; i < pend_n; i++) begin
      if (prio_of(s) > prio_of(pend[i])) begin
        at = i;
        break;
      end
    end
    for (int i = pend_n; i > at; i--) pend[i] = pend[i-1];
    pend[at] = s;
    pend_n++;
  endtask

  task automatic drop_src(npic_pkg::src_t s);
    int hit;
    if (!raised[s]) return;
    raised[s] = 1'b0;
    hit = -1;
    for (int i = 0; i < pend_n; i++) if (hit < 0 && pend[i] == s) hit = i;
    if (hit >= 0) begin
      for (int j = hit; j + 1 < pend_n; j++) pend[j] = pend[j+1];
      pend_n--;
    end
  endtask

  // next state and result for one event beat
  task automatic predict_event(npic_pkg::func_e f, npic_pkg::src_t s, logic [7:0] v,
                               output irq_res_t r);
    logic [2:0] fp;
    r = '0;
    case (f)
      npic_pkg::FUNC_RAISE: begin
        if (!raised[s]) begin
          raised[s] = 1'b1;
          if (enables[s]) begin
            enqueue_src(s);
            r.rnot = 1'b1;
          end
        end
      end
      npic_pkg::FUNC_CLEAR: drop_src(s);
      npic_pkg::FUNC_WRITE: begin
        fp = fpos_map[s*3 +: 3];
        if (v[fp]) drop_src(s);
      end
      npic_pkg::FUNC_ENABLE: begin
        if (v[0] != enables[s]) begin
          enables[s] = v[0];
          if (v[0] && raised[s] && remem_mask[s]) enqueue_src(s);
        end
      end
      npic_pkg::FUNC_GLOBAL: gcount = v;
      npic_pkg::FUNC_TICK: begin
        if (gcount > 8'd1) gcount--;
        else if (gcount == 8'd1 && pend_n > 0) begin
          if (!act_v || prio_of(pend[0]) > prio_of(act_src)) begin
            if (act_v && stack_n < npic_pkg::NumSrc) begin
              stack[stack_n] = act_src;
              stack_n++;
            end
            act_src = pend[0];
            act_v = 1'b1;
            r.taken = 1'b1;
            r.taken_src = act_src;
          end
        end
      end
      npic_pkg::FUNC_RETURN: begin
        if (!act_v) r.rerr = 1'b1;
        else begin
          if (aclr_mask[act_src]) drop_src(act_src);
          r.xnot = 1'b1;
          if (stack_n > 0) begin
            stack_n--;
            enqueue_src(stack[stack_n]);
          end
          act_v = 1'b0;
        end
      end
      default: ;
    endcase
    r.act_v = act_v;
    r.act_src = act_v ? act_src : '0;
    r.flags = raised;
  endtask

  // watch configuration, event and result beats
  always @(posedge clk_i or negedge rst_ni) begin
    irq_res_t exp_r, got_r;
    if (!rst_ni) begin
      prio_map = '0; aclr_mask = '0; remem_mask = '0; fpos_map = '0;
      raised = '0; enables = '0; gcount = '0; pend_n = 0;
      act_v = 1'b0; act_src = '0; stack_n = 0;
      errors_o <= 0;
      res_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (npic_pkg::reg_e'(cfg_index_i))
          npic_pkg::REG_PRIO:  prio_map = cfg_data_i[31:0];
          npic_pkg::REG_ACLR:  aclr_mask = cfg_data_i[15:0];
          npic_pkg::REG_REMEM: remem_mask = cfg_data_i[15:0];
          npic_pkg::REG_FPOS:  fpos_map = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got_r = '{taken_i, taken_source_i, active_valid_i, active_source_i, flags_i,
                  raise_notify_i, exit_notify_i, return_error_i};
        if (res_q.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, got_r);
          errors_o <= errors_o + 1;
        end else begin
          exp_r = res_q.pop_front();
          if (got_r !== exp_r) begin
            $display("%0t: mismatch expected %p actual %p", $time, exp_r, got_r);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_event(npic_pkg::func_e'(func_i), source_i, value_i, exp_r);
        res_q.push_back(exp_r);
      end
    end
  end
endmodule

@@ dv/tb_top.sv @@
// testbench top of the interrupt controller: stimulus and verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [47:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  func_i = '0;
  logic [3:0]  source_i = '0;
  logic [7:0]  value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        taken_o, active_valid_o, raise_notify_o, exit_notify_o, return_error_o;
  logic [3:0]  taken_source_o, active_source_o;
  logic [15:0] flags_o;
  int          errors, outstanding;
  int          idle_cycles = 0;
  int          out_hold = 0;

  localparam int WatchLimit = 20000;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  nested_priority_interrupt_controller_unit i_dut (.*);

  npic_checker i_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .func_i, .source_i, .value_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .taken_i(taken_o), .taken_source_i(taken_source_o),
    .active_valid_i(active_valid_o), .active_source_i(active_source_o),
    .flags_i(flags_o), .raise_notify_i(raise_notify_o),
    .exit_notify_i(exit_notify_o), .return_error_i(return_error_o),
    .errors_o(errors), .outstanding_o(outstanding)
  );

  function automatic int gap_len();
    int p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // watchdog on cycles with no beat accepted and no configuration write
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // result side back-pressure: a random gap after each taken beat
  always @(posedge clk_i) begin
    int g;
    if (out_valid_o && out_ready_i) begin
      g = gap_len();
      out_hold <= g;
      out_ready_i <= (g == 0);
    end else if (out_hold > 1) out_hold <= out_hold - 1;
    else begin
      out_hold <= 0;
      out_ready_i <= 1'b1;
    end
  end

  task automatic write_reg(npic_pkg::reg_e idx, logic [47:0] d);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // one event beat, with a random gap first
  task automatic send_event(npic_pkg::func_e f, logic [3:0] s, logic [7:0] v);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    source_i <= s;
    value_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic random_event(int bias);
    int p;
    logic [3:0] s;
    p = $urandom_range(0, 99);
    s = (bias != 0) ? 4'($urandom_range(0, 3)) : 4'($urandom);
    if (p < 20) send_event(npic_pkg::FUNC_RAISE, s, 8'($urandom));
    else if (p < 28) send_event(npic_pkg::FUNC_CLEAR, s, 8'($urandom));
    else if (p < 36) send_event(npic_pkg::FUNC_WRITE, s, 8'($urandom));
    else if (p < 48) send_event(npic_pkg::FUNC_ENABLE, s, 8'($urandom));
    else if (p < 53) send_event(npic_pkg::FUNC_GLOBAL, 4'($urandom),
                                ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                            : 8'(1 + $urandom_range(0, 2)));
    else if (p < 80) send_event(npic_pkg::FUNC_TICK, 4'($urandom), 8'($urandom));
    else if (p < 97) send_event(npic_pkg::FUNC_RETURN, 4'($urandom), 8'($urandom));
    else send_event(npic_pkg::FUNC_NONE, 4'($urandom), 8'($urandom));
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every event and the corner cases
    write_reg(npic_pkg::REG_PRIO, 48'hFFFF_0000);
    write_reg(npic_pkg::REG_ACLR, 48'hFFFF);
    write_reg(npic_pkg::REG_REMEM, 48'h0);
    write_reg(npic_pkg::REG_FPOS, 48'hFFFF_FFFF_FFFF);
    send_event(npic_pkg::FUNC_RETURN, 4'd0, 8'd0);
    send_event(npic_pkg::FUNC_RAISE, 4'd0, 8'd0);
    send_event(npic_pkg::FUNC_ENABLE, 4'd0, 8'hFE);
    send_event(npic_pkg::FUNC_ENABLE, 4'd15, 8'hFF);
    send_event(npic_pkg::FUNC_ENABLE, 4'd15, 8'h01);
    send_event(npic_pkg::FUNC_ENABLE, 4'd0, 8'h01);
    send_event(npic_pkg::FUNC_RAISE, 4'd0, 8'd0);
    send_event(npic_pkg::FUNC_RAISE, 4'd15, 8'd0);
    send_event(npic_pkg::FUNC_RAISE, 4'd15, 8'd0);
    send_event(npic_pkg::FUNC_GLOBAL, 4'd0, 8'd3);
    send_event(npic_pkg::FUNC_TICK, 4'd0, 8'd0);
    send_event(npic_pkg::FUNC_TICK, 4'd0, 8'd0);
    send_event(npic_pkg::FUNC_TICK, 4'd0, 8'd0);
    send_event(npic_pkg::FUNC_TICK, 4'd0, 8'd0);
    send_event(npic_pkg::FUNC_WRITE, 4'd15, 8'h7F);
    send_event(npic_pkg::FUNC_WRITE, 4'd15, 8'h80);
    send_event(npic_pkg::FUNC_RETURN, 4'd0, 8'd0);
    send_event(npic_pkg::FUNC_CLEAR, 4'd0, 8'd0);
    send_event(npic_pkg::FUNC_NONE, 4'd7, 8'hFF);
    send_event(npic_pkg::FUNC_GLOBAL, 4'd0, 8'hFF);
    send_event(npic_pkg::FUNC_GLOBAL, 4'd0, 8'd0);
    drain();

    // random phases through several settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(npic_pkg::REG_PRIO, 48'h0);
          write_reg(npic_pkg::REG_ACLR, 48'h0);
          write_reg(npic_pkg::REG_REMEM, 48'hFFFF);
          write_reg(npic_pkg::REG_FPOS, 48'h0);
        end
        5: begin
          write_reg(npic_pkg::REG_PRIO, 48'hFFFF_FFFF);
          write_reg(npic_pkg::REG_ACLR, 48'hFFFF);
          write_reg(npic_pkg::REG_REMEM, 48'h0);
          write_reg(npic_pkg::REG_FPOS, 48'hFFFF_FFFF_FFFF);
        end
        default: begin
          write_reg(npic_pkg::REG_PRIO, 48'($urandom));
          write_reg(npic_pkg::REG_ACLR, 48'($urandom));
          write_reg(npic_pkg::REG_REMEM, 48'($urandom));
          write_reg(npic_pkg::REG_FPOS, {16'($urandom), 32'($urandom)});
        end
      endcase
      send_event(npic_pkg::FUNC_GLOBAL, 4'd0, 8'd1);
      for (int n = 0; n < 250; n++) random_event((ph % 2) == 0 ? 0 : ($urandom_range(0, 1)));
      drain();
    end

    if (errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end
endmodule
